@@ hdl/edifact_segment_tokenizer_assert.svh @@
// Assertion helpers for the EDIFACT tokenizer.
`ifndef EDIFACT_SEGMENT_TOKENIZER_ASSERT_SVH
`define EDIFACT_SEGMENT_TOKENIZER_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define EST_ASSERT_SAME(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define EST_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ hdl/edst_pkg.sv @@
// ---------------------------------------------------------------------------
// edst_pkg
// Shared widths, codes and types of the EDIFACT segment tokenizer.
// ---------------------------------------------------------------------------
package edst_pkg;

   localparam int BYTE_W      = 8;
   localparam int TAG_W       = 24;
   localparam int KIND_W      = 3;
   localparam int ELEM_NUM_W  = 6;
   localparam int COMP_NUM_W  = 5;
   localparam int CSR_ADDR_W  = 3;
   localparam int CSR_DATA_W  = 24;
   localparam int RSP_TDATA_W = 48;
   localparam int RSP_PAD_W   = RSP_TDATA_W - BYTE_W - TAG_W - ELEM_NUM_W - COMP_NUM_W;

   localparam int Q_DEPTH = 4;
   localparam int Q_PTR_W = $clog2(Q_DEPTH);
   localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

   // Event kinds.
   localparam logic [KIND_W-1:0] EV_DATA     = 3'd0;
   localparam logic [KIND_W-1:0] EV_SUB_END  = 3'd1;
   localparam logic [KIND_W-1:0] EV_ELEM_END = 3'd2;
   localparam logic [KIND_W-1:0] EV_SEG_END  = 3'd3;
   localparam logic [KIND_W-1:0] EV_XCHG_END = 3'd4;
   localparam logic [KIND_W-1:0] EV_TAG      = 3'd5;

   // Register indexes.
   localparam logic [CSR_ADDR_W-1:0] CSR_SEG_TERM  = 3'd0;
   localparam logic [CSR_ADDR_W-1:0] CSR_ELEM_SEP  = 3'd1;
   localparam logic [CSR_ADDR_W-1:0] CSR_COMP_SEP  = 3'd2;
   localparam logic [CSR_ADDR_W-1:0] CSR_RELEASE   = 3'd3;
   localparam logic [CSR_ADDR_W-1:0] CSR_TRAILER   = 3'd4;

   // Register reset values.
   localparam logic [BYTE_W-1:0] RST_SEG_TERM = 8'd39;
   localparam logic [BYTE_W-1:0] RST_ELEM_SEP = 8'd43;
   localparam logic [BYTE_W-1:0] RST_COMP_SEP = 8'd58;
   localparam logic [BYTE_W-1:0] RST_RELEASE  = 8'd63;
   localparam logic [TAG_W-1:0]  RST_TRAILER  = 24'h554E5A;

   typedef struct packed {
      logic [BYTE_W-1:0] seg_term;
      logic [BYTE_W-1:0] elem_sep;
      logic [BYTE_W-1:0] comp_sep;
      logic [BYTE_W-1:0] release_byte;
      logic [TAG_W-1:0]  trailer_tag;
   } cfg_type;

   typedef struct packed {
      logic [KIND_W-1:0]     event_kind;
      logic [BYTE_W-1:0]     data_byte;
      logic [TAG_W-1:0]      segment_tag;
      logic [ELEM_NUM_W-1:0] element_number;
      logic [COMP_NUM_W-1:0] component_number;
   } result_type;

   typedef struct packed {
      logic       valid;
      result_type data;
   } push_type;

   typedef struct packed {
      logic       valid;
      result_type data;
   } head_type;

endpackage

@@ hdl/edst_front.sv @@
// ---------------------------------------------------------------------------
// edst_front
// Holds the delimiter registers and the tokenizer state, classifies each
// accepted byte and pushes the resulting event, if any, into the queue.
// ---------------------------------------------------------------------------
module edst_front
   import edst_pkg::*;
#(
   parameter int MAX_ELEMENT_INDEX   = 63,
   parameter int MAX_COMPONENT_INDEX = 31
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_we,
   input  logic [CSR_ADDR_W-1:0] csr_addr,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [BYTE_W-1:0]     req_tdata,
   input  logic                  req_tlast,
   input  logic                  q_full,
   output push_type              push
);

   localparam int EW = $clog2(MAX_ELEMENT_INDEX + 1);
   localparam int CW = $clog2(MAX_COMPONENT_INDEX + 1);

   localparam logic [1:0] PH_TAG  = 2'd0;
   localparam logic [1:0] PH_SKIP = 2'd1;
   localparam logic [1:0] PH_BODY = 2'd2;
   localparam logic [1:0] PH_DONE = 2'd3;

   cfg_type             cfg_ff;
   logic [1:0]          phase_ff, phase_in;
   logic [1:0]          tag_cnt_ff, tag_cnt_in;
   logic [TAG_W-1:0]    tag_ff, tag_in;
   logic                esc_ff, esc_in;
   logic [EW-1:0]       elem_ff, elem_in;
   logic [CW-1:0]       comp_ff, comp_in;
   logic                accept;
   logic [BYTE_W-1:0]   b;

   assign req_tready = !q_full;
   assign accept     = req_tvalid && req_tready;
   assign b          = req_tdata;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.seg_term     <= RST_SEG_TERM;
         cfg_ff.elem_sep     <= RST_ELEM_SEP;
         cfg_ff.comp_sep     <= RST_COMP_SEP;
         cfg_ff.release_byte <= RST_RELEASE;
         cfg_ff.trailer_tag  <= RST_TRAILER;
      end else if (csr_we) begin
         unique case (csr_addr)
            CSR_SEG_TERM: cfg_ff.seg_term     <= csr_wdata[BYTE_W-1:0];
            CSR_ELEM_SEP: cfg_ff.elem_sep     <= csr_wdata[BYTE_W-1:0];
            CSR_COMP_SEP: cfg_ff.comp_sep     <= csr_wdata[BYTE_W-1:0];
            CSR_RELEASE:  cfg_ff.release_byte <= csr_wdata[BYTE_W-1:0];
            CSR_TRAILER:  cfg_ff.trailer_tag  <= csr_wdata[TAG_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      phase_in   = phase_ff;
      tag_cnt_in = tag_cnt_ff;
      tag_in     = tag_ff;
      esc_in     = esc_ff;
      elem_in    = elem_ff;
      comp_in    = comp_ff;

      push.valid                 = 1'b0;
      push.data.event_kind       = EV_DATA;
      push.data.data_byte        = '0;
      push.data.segment_tag      = tag_ff;
      push.data.element_number   = ELEM_NUM_W'(elem_ff);
      push.data.component_number = COMP_NUM_W'(comp_ff);

      unique case (phase_ff)
         PH_TAG: begin
            tag_in     = {tag_ff[TAG_W-BYTE_W-1:0], b};
            tag_cnt_in = 2'(tag_cnt_ff + 2'd1);
            if (tag_cnt_ff == 2'd2) begin
               tag_cnt_in            = '0;
               phase_in              = PH_SKIP;
               push.valid            = 1'b1;
               push.data.event_kind  = EV_TAG;
               push.data.segment_tag = tag_in;
            end
         end
         PH_SKIP: begin
            phase_in = PH_BODY;
         end
         PH_BODY: begin
            // Delimiters are checked in a fixed order so equal settings resolve
            // the same way every time.
            priority if (esc_ff) begin
               esc_in              = 1'b0;
               push.valid          = 1'b1;
               push.data.data_byte = b;
            end else if (b == cfg_ff.release_byte) begin
               esc_in = 1'b1;
            end else if (b == cfg_ff.seg_term) begin
               push.valid = 1'b1;
               if (tag_ff == cfg_ff.trailer_tag) begin
                  push.data.event_kind = EV_XCHG_END;
                  phase_in             = PH_DONE;
               end else begin
                  push.data.event_kind = EV_SEG_END;
                  phase_in             = PH_TAG;
               end
               elem_in    = '0;
               comp_in    = '0;
               esc_in     = 1'b0;
               tag_cnt_in = '0;
               tag_in     = '0;
            end else if (b == cfg_ff.elem_sep) begin
               push.valid           = 1'b1;
               push.data.event_kind = EV_ELEM_END;
               if (elem_ff < EW'(MAX_ELEMENT_INDEX)) begin
                  elem_in = EW'(elem_ff + EW'(1));
               end
               comp_in = '0;
            end else if (b == cfg_ff.comp_sep) begin
               push.valid           = 1'b1;
               push.data.event_kind = EV_SUB_END;
               if (comp_ff < CW'(MAX_COMPONENT_INDEX)) begin
                  comp_in = CW'(comp_ff + CW'(1));
               end
            end else begin
               push.valid          = 1'b1;
               push.data.data_byte = b;
            end
         end
         PH_DONE: ;
         default: ;
      endcase

      if (req_tlast) begin
         phase_in   = PH_TAG;
         tag_cnt_in = '0;
         tag_in     = '0;
         esc_in     = 1'b0;
         elem_in    = '0;
         comp_in    = '0;
      end

      push.valid = push.valid && accept;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= PH_TAG;
         tag_cnt_ff <= '0;
         tag_ff     <= '0;
         esc_ff     <= 1'b0;
         elem_ff    <= '0;
         comp_ff    <= '0;
      end else if (accept) begin
         phase_ff   <= phase_in;
         tag_cnt_ff <= tag_cnt_in;
         tag_ff     <= tag_in;
         esc_ff     <= esc_in;
         elem_ff    <= elem_in;
         comp_ff    <= comp_in;
      end
   end

endmodule

@@ hdl/edst_queue.sv @@
// ---------------------------------------------------------------------------
// edst_queue
// Small first-in first-out buffer of events between the classifier and the
// output stage; push and pop may happen in the same cycle.
// ---------------------------------------------------------------------------
module edst_queue
   import edst_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  push_type push,
   output logic     q_full,
   output head_type head,
   input  logic     pop
);

   result_type         mem_ff [Q_DEPTH];
   logic [Q_PTR_W-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [Q_CNT_W-1:0] cnt_ff, cnt_in;
   logic               do_pop;

   assign q_full     = (cnt_ff == Q_CNT_W'(Q_DEPTH));
   assign head.valid = (cnt_ff != '0);
   assign head.data  = mem_ff[rd_ptr_ff];
   assign do_pop     = pop && head.valid;

   always_comb begin
      cnt_in = cnt_ff;
      if (push.valid && !do_pop) begin
         cnt_in = Q_CNT_W'(cnt_ff + Q_CNT_W'(1));
      end else if (do_pop && !push.valid) begin
         cnt_in = Q_CNT_W'(cnt_ff - Q_CNT_W'(1));
      end
   end

   always_ff @(posedge clock) begin
      if (push.valid) begin
         mem_ff[wr_ptr_ff] <= push.data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         cnt_ff <= cnt_in;
         if (push.valid) begin
            wr_ptr_ff <= Q_PTR_W'(wr_ptr_ff + Q_PTR_W'(1));
         end
         if (do_pop) begin
            rd_ptr_ff <= Q_PTR_W'(rd_ptr_ff + Q_PTR_W'(1));
         end
      end
   end

endmodule

@@ hdl/edst_back.sv @@
// ---------------------------------------------------------------------------
// edst_back
// Output register: takes the head of the queue whenever it is empty or its
// word is being taken, and drives the result channel.
// ---------------------------------------------------------------------------
module edst_back
   import edst_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  head_type               head,
   output logic                   pop,
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [RSP_TDATA_W-1:0] rsp_tdata,
   output logic [KIND_W-1:0]      rsp_tuser
);

   logic       valid_ff;
   result_type data_ff;

   assign pop = head.valid && (!valid_ff || rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (pop) begin
         valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         data_ff <= head.data;
      end
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tuser  = data_ff.event_kind;
   assign rsp_tdata  = {{RSP_PAD_W{1'b0}}, data_ff.component_number,
                        data_ff.element_number, data_ff.segment_tag, data_ff.data_byte};

endmodule

@@ hdl/edifact_segment_tokenizer.sv @@
// ---------------------------------------------------------------------------
// edifact_segment_tokenizer
// Splits an EDIFACT interchange, one byte per word, into tag, data and
// delimiter events with segment tag and element/subelement indices.
// ---------------------------------------------------------------------------
//   channel   direction  handshake          payload
//   req_      in         tvalid/tready      tdata: byte, tlast: end of message
//   rsp_      out        tvalid/tready      tdata: byte/tag/indices, tuser: kind
//   csr_      in         we (no wait)       addr: register index, wdata
//
// One byte is accepted every cycle while the four-entry event queue has room;
// its event is written into the queue and then registered in the output register.
// The queue plus the output register absorb result stalls; req_tready falls
// only when the queue is full. Synchronous reset restores the delimiter
// defaults and the start state; no clearing pass is needed.
// ---------------------------------------------------------------------------
module edifact_segment_tokenizer
   import edst_pkg::*;
#(
   parameter int MAX_ELEMENT_INDEX   = 63,
   parameter int MAX_COMPONENT_INDEX = 31
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_we,
   input  logic [CSR_ADDR_W-1:0]  csr_addr,
   input  logic [CSR_DATA_W-1:0]  csr_wdata,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [BYTE_W-1:0]      req_tdata,   // [7:0] in_byte
   input  logic                   req_tlast,
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   // [7:0] data_byte, [31:8] segment_tag, [37:32] element_number,
   // [42:38] component_number, [47:43] zero
   output logic [RSP_TDATA_W-1:0] rsp_tdata,
   output logic [KIND_W-1:0]      rsp_tuser    // [2:0] event_kind
);

`include "edifact_segment_tokenizer_assert.svh"

   push_type push;
   head_type head;
   logic     q_full;
   logic     pop;

   edst_front #(
      .MAX_ELEMENT_INDEX   (MAX_ELEMENT_INDEX),
      .MAX_COMPONENT_INDEX (MAX_COMPONENT_INDEX)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .q_full     (q_full),
      .push       (push)
   );

   edst_queue u_queue (
      .clock  (clock),
      .reset  (reset),
      .push   (push),
      .q_full (q_full),
      .head   (head),
      .pop    (pop)
   );

   edst_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head       (head),
      .pop        (pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   // Only data events carry a byte.
   `EST_ASSERT_SAME(a_byte_only_on_data, clock, reset,
      rsp_tvalid && (rsp_tuser != EV_DATA), rsp_tdata[BYTE_W-1:0] == '0,
      "non-data event carries a data byte")

   // A tag event carries zero element and subelement indices.
   `EST_ASSERT_SAME(a_tag_indices_zero, clock, reset,
      rsp_tvalid && (rsp_tuser == EV_TAG), rsp_tdata[42:32] == '0,
      "tag event with nonzero indices")

   // An event taken from the queue is in the output register next cycle.
   `EST_ASSERT_NEXT(a_pop_loads_output, clock, reset,
      pop, rsp_tvalid && (rsp_tuser == $past(head.data.event_kind)),
      "queue head not loaded into the output register")

endmodule
